@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, held off while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define IRTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define IRTL_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/core/irtl_pkg.sv @@
// ----------------------------------------------------------------------------
// irtl_pkg
// widths, codes, state type and control structs of the range table lookup
// ----------------------------------------------------------------------------
package irtl_pkg;

  localparam int TABLE_DEPTH_DEF = 65536;

  localparam int COUNT_W = 17;
  localparam int INDEX_W = 16;
  localparam int IP_W    = 32;
  localparam int OFS_W   = 24;
  localparam int ENTRY_W = IP_W + OFS_W;

  // item command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_PROBE,
    ST_RESULT
  } irtl_state_t;

  // controller to datapath
  typedef struct packed {
    logic write;  // store one table entry
    logic start;  // latch query of an accepted lookup
    logic init;   // set up search bounds, first probe read
    logic probe;  // compare probed entry, narrow bounds
    logic emit;   // load result register
  } irtl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero; // no entries take part in the search
    logic more;   // search interval still open after this probe
  } irtl_sts_t;

endpackage

@@ rtl/core/irtl_if.sv @@
// ----------------------------------------------------------------------------
// irtl channel interfaces
// valid/ready channels for lookup items, result items and the count register
// ----------------------------------------------------------------------------
interface irtl_in_if import irtl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [INDEX_W-1:0] entry_index;
  logic [IP_W-1:0]    entry_start_ip;
  logic [OFS_W-1:0]   entry_rec_ofs;
  logic [IP_W-1:0]    query_ip;

  modport source (output valid, cmd, entry_index, entry_start_ip, entry_rec_ofs,
                  query_ip, input ready);
  modport sink   (input valid, cmd, entry_index, entry_start_ip, entry_rec_ofs,
                  query_ip, output ready);
endinterface

interface irtl_out_if import irtl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [OFS_W-1:0]   rec_ofs;
  logic [INDEX_W-1:0] match_index;

  modport source (output valid, found, rec_ofs, match_index, input ready);
  modport sink   (input valid, found, rec_ofs, match_index, output ready);
endinterface

interface irtl_cfg_if import irtl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

@@ rtl/core/irtl_ctrl.sv @@
// ----------------------------------------------------------------------------
// irtl_ctrl
// sequencer of the range lookup: handshakes, search steps, result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irtl_ctrl import irtl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  irtl_sts_t sts,
  output irtl_cmd_t cmd
);

  irtl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        res_free;

  assign res_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_LOOKUP) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        state_nxt = sts.n_zero ? ST_RESULT : ST_PROBE;
      end
      ST_PROBE: begin
        if (!sts.more) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.write = in_valid && in_cmd == CMD_WRITE;
        cmd.start = in_valid && in_cmd == CMD_LOOKUP;
      end
      ST_INIT: begin
        cmd.init = 1'b1;
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
      end
      ST_RESULT: begin
        cmd.emit = res_free;
        if (res_free) out_valid_nxt = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `IRTL_ASSERT(a_lookup_starts, (in_valid && in_ready && in_cmd == CMD_LOOKUP) |=> state_r == ST_INIT, "accepted lookup did not start a search")
  `IRTL_ASSERT(a_emit_shows, cmd.emit |=> out_valid_r, "loaded result not offered")
  `IRTL_ASSERT(a_search_ends, (state_r == ST_PROBE && !sts.more) |=> state_r == ST_RESULT, "closed search kept probing")

endmodule

@@ rtl/core/irtl_dp.sv @@
// ----------------------------------------------------------------------------
// irtl_dp
// range table memory, count register, bisection bounds and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irtl_dp import irtl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  irtl_cmd_t          cmd,
  output irtl_sts_t          sts,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_count,
  input  logic [INDEX_W-1:0] wr_index,
  input  logic [IP_W-1:0]    wr_start,
  input  logic [OFS_W-1:0]   wr_offset,
  input  logic [IP_W-1:0]    query_ip,
  output logic               res_found,
  output logic [OFS_W-1:0]   res_offset,
  output logic [INDEX_W-1:0] res_index
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  logic [COUNT_W-1:0] entry_count_r;
  logic [IP_W-1:0]    q_r;
  logic [CW-1:0]      lo_r, hi_r, mid_r;
  logic               found_r;
  logic [OFS_W-1:0]   best_ofs_r;
  logic [CW-1:0]      best_idx_r;
  logic [ENTRY_W-1:0] rd_data_r;
  logic               res_found_r;
  logic [OFS_W-1:0]   res_ofs_r;
  logic [INDEX_W-1:0] res_idx_r;

  logic [CW-1:0] n_sat, mid_inc, mid_right, mid_left, next_mid;
  logic          go_right, more_right, more_left, rd_en, wr_ok;
  logic [AW-1:0] rd_addr, wr_addr;

  // count above the table saturates to the table depth
  always_comb begin
    if (32'(entry_count_r) > 32'(TABLE_DEPTH)) n_sat = CW'(TABLE_DEPTH);
    else n_sat = CW'(entry_count_r);
  end

  // both possible next probes worked out beside the compare
  assign go_right   = rd_data_r[ENTRY_W-1:OFS_W] <= q_r;
  assign mid_inc    = mid_r + CW'(1);
  assign mid_right  = mid_inc + ((hi_r - mid_inc) >> 1);
  assign mid_left   = lo_r + ((mid_r - lo_r) >> 1);
  assign more_right = mid_inc < hi_r;
  assign more_left  = lo_r < mid_r;

  always_comb begin
    if (cmd.init) next_mid = n_sat >> 1;
    else if (go_right) next_mid = mid_right;
    else next_mid = mid_left;
  end

  assign sts.n_zero = n_sat == '0;
  assign sts.more   = go_right ? more_right : more_left;

  assign rd_en   = (cmd.init && !sts.n_zero) || (cmd.probe && sts.more);
  assign rd_addr = AW'(next_mid);
  assign wr_addr = AW'(wr_index);
  assign wr_ok   = 32'(wr_index) < 32'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) mem[wr_addr] <= {wr_start, wr_offset};
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r     <= query_ip;
      found_r <= 1'b0;
    end
    if (cmd.init) begin
      lo_r  <= '0;
      hi_r  <= n_sat;
      mid_r <= next_mid;
    end
    if (cmd.probe) begin
      mid_r <= next_mid;
      if (go_right) begin
        lo_r       <= mid_inc;
        found_r    <= 1'b1;
        best_ofs_r <= rd_data_r[OFS_W-1:0];
        best_idx_r <= mid_r;
      end else begin
        hi_r <= mid_r;
      end
    end
    if (cmd.emit) begin
      res_found_r <= found_r;
      res_ofs_r   <= found_r ? best_ofs_r : '0;
      res_idx_r   <= found_r ? INDEX_W'(best_idx_r) : '0;
    end
  end

  assign res_found  = res_found_r;
  assign res_offset = res_ofs_r;
  assign res_index  = res_idx_r;

  `IRTL_ASSERT(a_probe_in_bounds, cmd.probe |-> (lo_r <= mid_r && mid_r < hi_r), "probe outside search interval")
  `IRTL_ASSERT(a_right_finds, (cmd.probe && go_right) |=> found_r, "right move not recorded as hit")
  `IRTL_ASSERT(a_miss_zero, cmd.emit |=> (res_found_r || (res_ofs_r == '0 && res_idx_r == '0)), "miss result not zero")

endmodule

@@ rtl/core/ip_range_table_lookup.sv @@
// ----------------------------------------------------------------------------
// ip_range_table_lookup
// ipv4 range table: entry writes and bisection lookups over sorted starts
// ----------------------------------------------------------------------------
// A write item stores one (start, record offset) entry and gives no result. A
// lookup item bisects the first entry_count entries (capped at TABLE_DEPTH)
// and answers with the last entry whose start is at or below the query, or not
// found. One item is in work at a time: no new item is accepted until the
// lookup is back in idle. A lookup runs a setup step, then one probe per cycle
// through the single read port of the table memory, then a result step that
// loads the result register once the previous result has been taken. The
// table is not cleared at reset; entries must be written before a lookup can
// reach them.
// ----------------------------------------------------------------------------
module ip_range_table_lookup import irtl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  irtl_in_if.sink    in_chan,
  irtl_out_if.source out_chan,
  irtl_cfg_if.sink   cfg_chan
);

  irtl_cmd_t cmd;
  irtl_sts_t sts;

  // count register takes a write in any cycle
  assign cfg_chan.ready = 1'b1;

  // sequencer: owns both handshakes and steps the search
  irtl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_cmd    (in_chan.cmd),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table memory, bounds and result register
  irtl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_chan.valid),
    .cfg_count  (cfg_chan.entry_count),
    .wr_index   (in_chan.entry_index),
    .wr_start   (in_chan.entry_start_ip),
    .wr_offset  (in_chan.entry_rec_ofs),
    .query_ip   (in_chan.query_ip),
    .res_found  (out_chan.found),
    .res_offset (out_chan.rec_ofs),
    .res_index  (out_chan.match_index)
  );

endmodule
